### hw/rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and types for the integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package i2da_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int IN_DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
	localparam int CHAR_BITS      = 8;
	localparam int DAB_STAGES     = 4;
	localparam int STEP_BITS      = VALUE_BITS / DAB_STAGES;
	localparam int LAST_STEP_BITS = VALUE_BITS - (DAB_STAGES - 1) * STEP_BITS;
	localparam int DIGITS         = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int BCD_BITS       = DIGITS * 4;
	localparam int IDX_BITS       = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 8'h30;
	localparam logic [CHAR_BITS-1:0] MINUS_CODE = 8'h2D;

	typedef struct packed {
		logic                  neg;
		logic [BCD_BITS-1:0]   bcd;
		logic [VALUE_BITS-1:0] bin;
	} dab_t;

endpackage

### hw/rtl/int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Converts signed integers to decimal ASCII text, one character per word.
// ----------------------------------------------------------------------------
// Pipeline: an input word passes one magnitude stage, four shift-add-3 stages
//   and one character register before its first character can be taken.
// Throughput: one character per cycle while m_axis_tready is high; a number
//   of n characters (1 to 11) is sent as n words by the single serializer.
// Reset: arst_n clears all valid bits and the serializer; no words in flight.
module int_to_decimal_ascii_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [i2da_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // value
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [i2da_pkg::CHAR_BITS-1:0]      m_axis_tdata,  // char_code
	output logic                                m_axis_tlast
);
	import i2da_pkg::*;

	function automatic dab_t dab_group(input dab_t d, input bit last_group);
		dab_t r;
		r = d;
		for (int s = 0; s < LAST_STEP_BITS; s++) begin
			if (last_group || (s < STEP_BITS)) begin
				for (int i = 0; i < DIGITS; i++) begin
					if (r.bcd[i*4 +: 4] >= 4'd5)
						r.bcd[i*4 +: 4] = r.bcd[i*4 +: 4] + 4'd3;
				end
				{r.bcd, r.bin} = {r.bcd[BCD_BITS-2:0], r.bin, 1'b0};
			end
		end
		return r;
	endfunction

	dab_t                  stage_s [DAB_STAGES+1];
	logic                  valid_s [DAB_STAGES+1];
	logic                  adv     [DAB_STAGES+2];

	logic [VALUE_BITS-1:0] raw;
	logic                  raw_neg;

	logic [BCD_BITS-1:0]   digits_q;
	logic                  neg_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic                  busy_q;
	logic                  out_fire;
	logic                  finish;
	logic                  load;
	logic [IDX_BITS-1:0]   msd;
	logic [3:0]            cur_digit;

	assign raw     = s_axis_tdata[VALUE_BITS-1:0];
	assign raw_neg = raw[VALUE_BITS-1];

	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign finish   = out_fire && !neg_q && (idx_q == '0);
	assign load     = valid_s[DAB_STAGES] && (!busy_q || finish);

	always_comb begin
		adv[DAB_STAGES+1] = load;
		for (int k = DAB_STAGES; k >= 0; k--)
			adv[k] = !valid_s[k] || adv[k+1];
	end

	assign s_axis_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DAB_STAGES; k++)
				valid_s[k] <= 1'b0;
		end else begin
			if (adv[0])
				valid_s[0] <= s_axis_tvalid;
			for (int k = 1; k <= DAB_STAGES; k++) begin
				if (adv[k])
					valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && s_axis_tvalid) begin
			stage_s[0].neg <= raw_neg;
			stage_s[0].bcd <= '0;
			stage_s[0].bin <= raw_neg ? (~raw + 1'b1) : raw;
		end
		for (int k = 1; k <= DAB_STAGES; k++) begin
			if (adv[k] && valid_s[k-1])
				stage_s[k] <= dab_group(stage_s[k-1], (k == DAB_STAGES));
		end
	end

	always_comb begin
		msd = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (stage_s[DAB_STAGES].bcd[i*4 +: 4] != 4'd0)
				msd = IDX_BITS'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			neg_q  <= stage_s[DAB_STAGES].neg;
			idx_q  <= msd;
		end else if (out_fire) begin
			if (neg_q)
				neg_q <= 1'b0;
			else if (idx_q == '0)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			digits_q <= stage_s[DAB_STAGES].bcd;
	end

	assign cur_digit     = digits_q[idx_q*4 +: 4];
	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = neg_q ? MINUS_CODE : (DIGIT_BASE + CHAR_BITS'(cur_digit));
	assign m_axis_tlast  = !neg_q && (idx_q == '0);

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && neg_q |-> !m_axis_tlast)
		else $error("minus sign flagged as last character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !neg_q |-> cur_digit <= 4'd9)
		else $error("non-decimal digit on output");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < IDX_BITS'(DIGITS))
		else $error("digit index out of range");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_fire |=> busy_q && $stable(idx_q) && $stable(neg_q))
		else $error("serializer moved without a taken word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DAB_STAGES] && !load |=> valid_s[DAB_STAGES])
		else $error("converted number dropped");

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for int_to_decimal_ascii_unit. Signed integers go in one
// word at a time; each is predicted into its expected decimal characters,
// and every output word is checked in order for its character code and last
// flag. Edge values are sent first, then random values, random text lengths
// and decade boundaries in bursts, with gaps on input and stalls on output.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import i2da_pkg::*;

	localparam int           RADIX        = 10;
	localparam int           DRAIN_CYCLES = 24;
	localparam int unsigned  CYCLE_LIMIT  = 600000;
	localparam longint       MAG_LIMIT    = longint'(1) << (VALUE_BITS - 1);

	typedef struct packed {
		logic [CHAR_BITS-1:0] char_code;
		logic                 last;
	} text_char_t;

	typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [CHAR_BITS-1:0]    m_axis_tdata;
	logic                    m_axis_tlast;

	text_char_t   expected_chars[$];
	int unsigned  fail_count  = 0;
	int unsigned  cycle_count = 0;

	ready_mode_t  ready_mode    = READY_ALWAYS;
	logic [15:0]  ready_pattern = 16'hFFFF;
	logic [3:0]   pattern_idx   = '0;
	int           burst_left    = 1;
	int           burst_max     = 8;
	int           gap_max       = 0;

	int_to_decimal_ascii_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("int_to_decimal_ascii_unit regression: fail");
			$finish;
		end
	end

	// output stall
	always @(posedge clk) begin
		pattern_idx <= pattern_idx + 1'b1;
		case (ready_mode)
			READY_ALWAYS: begin
				m_axis_tready <= 1'b1;
			end
			READY_RANDOM: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				m_axis_tready <= ready_pattern[pattern_idx];
			end
		endcase
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected word: char_code %h last %b", m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== want.char_code) begin
					$error("char_code: expected %h, got %h", want.char_code, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
		logic                  negative;
		logic [VALUE_BITS-1:0] magnitude;
		logic [3:0]            digit;
		logic [3:0]            digit_q[$];
		negative  = value[VALUE_BITS-1];
		magnitude = negative ? (~value + 1'b1) : value;
		do begin
			digit_q.push_front(4'(magnitude % RADIX));
			magnitude = magnitude / RADIX;
		end while (magnitude != 0);
		if (negative)
			expected_chars.push_back('{char_code: MINUS_CODE, last: 1'b0});
		while (digit_q.size() > 0) begin
			digit = digit_q.pop_front();
			expected_chars.push_back('{char_code: DIGIT_BASE + CHAR_BITS'(digit),
				last: (digit_q.size() == 0)});
		end
	endfunction

	task automatic send_value(input logic [VALUE_BITS-1:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_BITS'(value);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_text(value);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, burst_max);
			if (gap_max > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max))
					@(posedge clk);
			end
		end
	endtask

	task automatic end_phase();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] signed_of(input longint mag, input bit negative);
		return negative ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
	endfunction

	task automatic test_edge_values();
		logic [VALUE_BITS-1:0] edge_values[$];
		edge_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
			32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd7, 32'd1000000, -32'sd1};
		ready_mode = READY_ALWAYS;
		gap_max    = 0;
		foreach (edge_values[i])
			send_value(edge_values[i]);
		end_phase();
	endtask

	task automatic test_full_range();
		ready_mode = READY_RANDOM;
		burst_max  = 12;
		gap_max    = 5;
		repeat (120)
			send_value(VALUE_BITS'($urandom()));
		end_phase();
	endtask

	task automatic test_text_lengths();
		int     n_digits;
		bit     negative;
		longint lo;
		longint hi;
		longint pow;
		ready_mode    = READY_PATTERN;
		ready_pattern = 16'($urandom()) | 16'h0001;
		burst_max     = 20;
		gap_max       = 3;
		repeat (180) begin
			n_digits = $urandom_range(1, 10);
			negative = 1'($urandom_range(0, 1));
			pow = 1;
			repeat (n_digits - 1)
				pow = pow * RADIX;
			lo = (n_digits == 1) ? 0 : pow;
			hi = pow * RADIX - 1;
			if (negative && hi > MAG_LIMIT)
				hi = MAG_LIMIT;
			if (!negative && hi > MAG_LIMIT - 1)
				hi = MAG_LIMIT - 1;
			send_value(signed_of(lo + longint'($urandom_range(0, int'(hi - lo))), negative));
		end
		end_phase();
	endtask

	task automatic test_decade_boundaries();
		longint pow;
		longint mag;
		ready_mode    = READY_PATTERN;
		ready_pattern = 16'($urandom()) | 16'h8000;
		burst_max     = 4;
		gap_max       = 8;
		pow = RADIX;
		repeat (9) begin
			for (int off = -2; off <= 1; off++) begin
				mag = pow + off;
				send_value(signed_of(mag, 1'b0));
				send_value(signed_of(mag, 1'b1));
			end
			pow = pow * RADIX;
		end
		end_phase();
	endtask

	task automatic test_back_to_back();
		ready_mode = READY_ALWAYS;
		burst_max  = 64;
		gap_max    = 0;
		repeat (60) begin
			if ($urandom_range(0, 1))
				send_value(VALUE_BITS'($urandom()));
			else
				send_value(VALUE_BITS'($urandom_range(0, 19)) - VALUE_BITS'(10));
		end
		end_phase();
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_values();
		test_full_range();
		test_text_lengths();
		test_decade_boundaries();
		test_back_to_back();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("int_to_decimal_ascii_unit regression: pass");
		else
			$display("int_to_decimal_ascii_unit regression: fail");
		$finish;
	end

endmodule
